/* sv/keyed_min_cost_table_unit_assert.svh */
// Assertion macros shared by the table unit RTL.
`ifndef KEYED_MIN_COST_TABLE_UNIT_ASSERT_SVH
`define KEYED_MIN_COST_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define KMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/kmc_pkg.sv */
package kmc_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned LinkW  = 32;
  localparam int unsigned CostW  = 32;
  localparam int unsigned CountW = 7;

  // command codes; code 3 is unused and changes nothing
  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } kmc_cmd_t;

  // word travelling down the cell chain
  typedef struct packed {
    logic             valid;
    kmc_cmd_t         cmd;
    logic [KeyW-1:0]  key;
    logic [LinkW-1:0] link;
    logic [CostW-1:0] cost;
    logic             found;     // key matched a valid cell
    logic             done;      // a cell has settled the word
    logic             inserted;  // a free cell took the key
    logic [LinkW-1:0] olink;
    logic [CostW-1:0] ocost;
  } kmc_token_t;

  // result word
  typedef struct packed {
    logic              found;
    logic [LinkW-1:0]  olink;
    logic [CostW-1:0]  ocost;
    logic [CountW-1:0] entry_count;
    logic              full;
  } kmc_result_t;

endpackage

/* sv/kmc_if.sv */
// Input channel: one command word per handshake
interface kmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [kmc_pkg::KeyW-1:0]   node_key;
  logic [kmc_pkg::LinkW-1:0]  link_id;
  logic [kmc_pkg::CostW-1:0]  cost;

  modport source (output valid, command, node_key, link_id, cost, input ready);
  modport sink   (input valid, command, node_key, link_id, cost, output ready);
endinterface

// Result channel: one result word per handshake
interface kmc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [kmc_pkg::LinkW-1:0]   out_link;
  logic [kmc_pkg::CostW-1:0]   out_cost;
  logic [kmc_pkg::CountW-1:0]  entry_count;
  logic                        table_full;

  modport source (output valid, found, out_link, out_cost, entry_count, table_full,
                  input ready);
  modport sink   (input valid, found, out_link, out_cost, entry_count, table_full,
                  output ready);
endinterface

/* sv/keyed_min_cost_table_unit.sv */
// Keyed minimum-cost table: TABLE_ENTRIES cells in a row, each holding one
// (key, link, cost) entry. A command word enters the first cell when
// accepted and moves one cell per clock; the cell holding the key (or the
// first free cell, for an update of a new key) acts on it. The word passes
// the register of every cell in turn and its result is then registered at
// the output. Only one command is in the chain at a time: the next one is
// accepted only after the word has left the last cell.
// A clear empties every cell as it passes. A result waiting at the output
// does not block the next command: a second result register holds one more.
// Ties on cost keep the stored pair; an update of a new key into a full
// table is dropped and flagged with table_full.
module keyed_min_cost_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input logic       clk,
  input logic       rst_n,
  kmc_in_if.sink    in_ch,
  kmc_out_if.source out_ch
);
  import kmc_pkg::*;

  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned WideW = (CntW > CountW) ? CntW : CountW;

  kmc_token_t tok [TABLE_ENTRIES+1];

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            out_v_r, out_v_nxt;
  logic            spare_v_r, spare_v_nxt;
  kmc_result_t     out_d_r, out_d_nxt;
  kmc_result_t     spare_d_r, spare_d_nxt;
  kmc_result_t     res;
  kmc_token_t      last;
  logic            accept, emerge, out_take;
  logic [WideW-1:0] count_wide;

  assign in_ch.ready = !busy_r && !spare_v_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // head of the chain
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = accept;
    tok[0].cmd      = kmc_cmd_t'(in_ch.command);
    tok[0].key      = in_ch.node_key;
    tok[0].link     = in_ch.link_id;
    tok[0].cost     = in_ch.cost;
  end

  // row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    kmc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  assign last   = tok[TABLE_ENTRIES];
  assign emerge = last.valid;

  // entry count and result word
  always_comb begin
    count_nxt = count_r;
    if (emerge) begin
      if (last.cmd == CMD_CLEAR) begin
        count_nxt = '0;
      end else if (last.inserted) begin
        count_nxt = count_r + CntW'(1);
      end
    end
    count_wide      = WideW'(count_nxt);
    res.found       = last.found;
    res.olink       = last.olink;
    res.ocost       = last.ocost;
    res.entry_count = count_wide[CountW-1:0];
    res.full        = (last.cmd == CMD_UPDATE) && !last.done;
  end

  assign busy_nxt = accept ? 1'b1 : (emerge ? 1'b0 : busy_r);

  // two-word output buffer
  assign out_take = out_v_r && out_ch.ready;

  always_comb begin
    out_v_nxt   = out_v_r;
    out_d_nxt   = out_d_r;
    spare_v_nxt = spare_v_r;
    spare_d_nxt = spare_d_r;
    if (!out_v_r || out_take) begin
      if (spare_v_r) begin
        out_v_nxt   = 1'b1;
        out_d_nxt   = spare_d_r;
        spare_v_nxt = emerge;
        spare_d_nxt = res;
      end else begin
        out_v_nxt = emerge;
        out_d_nxt = res;
      end
    end else if (emerge) begin
      spare_v_nxt = 1'b1;
      spare_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      count_r   <= '0;
      out_v_r   <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      count_r   <= count_nxt;
      out_v_r   <= out_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r   <= out_d_nxt;
    spare_d_r <= spare_d_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.found       = out_d_r.found;
  assign out_ch.out_link    = out_d_r.olink;
  assign out_ch.out_cost    = out_d_r.ocost;
  assign out_ch.entry_count = out_d_r.entry_count;
  assign out_ch.table_full  = out_d_r.full;

  // checks
`include "keyed_min_cost_table_unit_assert.svh"

  `KMC_ASSERT_NOW(a_emerge_busy, emerge, busy_r, "word left chain with no command in flight")
  `KMC_ASSERT_NEXT(a_accept_busy, accept, busy_r && !emerge, "accepted word not tracked")
  `KMC_ASSERT_NOW(a_spare_order, spare_v_r, out_v_r, "spare result held ahead of output")
  `KMC_ASSERT_NOW(a_count_range, 1'b1, count_r <= CntW'(TABLE_ENTRIES), "entry count overflow")
  `KMC_ASSERT_NOW(a_emerge_room, emerge, !spare_v_r, "result arrived with no room to hold it")

endmodule

/* sv/kmc_cell.sv */
// One table entry; inspects the passing word and hands it on through its register.
module kmc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  kmc_pkg::kmc_token_t tok_i,
  output kmc_pkg::kmc_token_t tok_o
);
  import kmc_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KeyW-1:0]  key_r, key_nxt;
  logic [LinkW-1:0] link_r, link_nxt;
  logic [CostW-1:0] cost_r, cost_nxt;
  kmc_token_t       tok_r, tok_nxt;

  logic live, hit, vacant, lower;

  assign live   = tok_i.valid && !tok_i.done;
  assign hit    = live && valid_r && (key_r == tok_i.key);
  assign vacant = live && !valid_r;
  assign lower  = tok_i.cost < cost_r;

  // entry update and word hand-on
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    link_nxt  = link_r;
    cost_nxt  = cost_r;
    tok_nxt   = tok_i;
    case (tok_i.cmd)
      CMD_UPDATE: begin
        if (hit) begin
          tok_nxt.found = 1'b1;
          tok_nxt.done  = 1'b1;
          if (lower) begin
            link_nxt = tok_i.link;
            cost_nxt = tok_i.cost;
          end
          tok_nxt.olink = lower ? tok_i.link : link_r;
          tok_nxt.ocost = lower ? tok_i.cost : cost_r;
        end else if (vacant) begin
          // valid cells are packed from the head, so the key is absent
          valid_nxt        = 1'b1;
          key_nxt          = tok_i.key;
          link_nxt         = tok_i.link;
          cost_nxt         = tok_i.cost;
          tok_nxt.done     = 1'b1;
          tok_nxt.inserted = 1'b1;
          tok_nxt.olink    = tok_i.link;
          tok_nxt.ocost    = tok_i.cost;
        end
      end
      CMD_LOOKUP: begin
        if (hit) begin
          tok_nxt.found = 1'b1;
          tok_nxt.done  = 1'b1;
          tok_nxt.olink = link_r;
          tok_nxt.ocost = cost_r;
        end else if (vacant) begin
          tok_nxt.done = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (tok_i.valid) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    link_r <= link_nxt;
    cost_r <= cost_nxt;
  end

  assign tok_o = tok_r;

endmodule
